>>> hdl/lcdw_pkg.sv
// Shared types, codes and helpers for the character LCD write sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none
package lcdw_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CSR_IW   = 2;
   localparam int unsigned REQ_DW   = 16;
   localparam int unsigned REQ_UW   = 2;
   localparam int unsigned RSP_DW   = 16;

   localparam logic [BYTE_W-1:0] WRITE_TICKS_RST = 8'd20;
   localparam logic [BYTE_W-1:0] READ_TICKS_RST  = 8'd10;
   localparam logic [BYTE_W-1:0] TICK_MAX        = 8'hFF;

   typedef enum logic [CSR_IW-1:0] {
      CSR_WRITE_TICKS = 2'd0,
      CSR_READ_TICKS  = 2'd1,
      CSR_REVERSE     = 2'd2
   } lcdw_csr_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_WRITE = 4'b0010,
      PH_GAP   = 4'b0100,
      PH_READ  = 4'b1000
   } lcdw_phase_type;

   typedef struct packed {
      logic              ready_res;
      logic              drive_bus;
      logic [BYTE_W-1:0] pin_data;
      logic              pin_en;
      logic              pin_rw;
      logic              pin_rs;
   } lcdw_res_type;

   function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = v[BYTE_W-1-i];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/char_lcd_write_busy_poll.sv
// Top level of the character LCD write sequencer with busy-flag polling.
// Depends on lcdw_pkg, lcdw_seq and lcdw_obuf.
//
// Every accepted item is one tick of the LCD pin sequencer and gives exactly one
// result: the rs/rw/en/data pin levels after that tick plus a ready flag. An item
// is sequenced combinationally into a two-entry result buffer, so one
// item is accepted per cycle while the result side keeps up; req_tready only drops
// when both buffer entries hold results not yet taken. Write requests arriving
// outside idle are treated as plain ticks. Configuration is written by index
// (0 write pulse ticks, 1 read pulse ticks, 2 bit reversal) while no item is in
// flight.
`default_nettype none
module char_lcd_write_busy_poll
   import lcdw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [CSR_IW-1:0] csr_addr,
   input  wire logic [BYTE_W-1:0] csr_wdata,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_DW-1:0] req_tdata,   // write_byte[7:0], busy_pin[8], zero pad
   input  wire logic [REQ_UW-1:0] req_tuser,   // opcode[0], is_data[1]
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_DW-1:0]      rsp_tdata    // pin_rs, pin_rw, pin_en, pin_data[10:3],
                                               // drive_bus, ready_res, zero pad
);

   logic         step;
   lcdw_res_type seq_res, out_res;

   assign step = req_tvalid & req_tready;

   lcdw_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .step       (step),
      .opcode     (req_tuser[0]),
      .is_data    (req_tuser[1]),
      .write_byte (req_tdata[BYTE_W-1:0]),
      .busy_pin   (req_tdata[BYTE_W]),
      .res        (seq_res)
   );

   lcdw_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_res  (seq_res),
      .space     (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = {3'b000, out_res};

   a_bus_released : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_res.drive_bus) |-> (out_res.pin_data == '0 && out_res.pin_rw))
      else $error("data bus not released while undriven");

   a_idle_pins : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_res.ready_res) |-> (!out_res.pin_en && !out_res.drive_bus))
      else $error("enable or bus driven while idle");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty result register");

endmodule
`default_nettype wire

>>> hdl/lcdw_seq.sv
// Pin sequencer: configuration registers, phase/tick state and pin levels per item.
// Depends on lcdw_pkg.
`default_nettype none
module lcdw_seq
   import lcdw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IW-1:0]     csr_addr,
   input  wire logic [BYTE_W-1:0]     csr_wdata,
   input  wire logic                  step,
   input  wire logic                  opcode,
   input  wire logic                  is_data,
   input  wire logic [BYTE_W-1:0]     write_byte,
   input  wire logic                  busy_pin,
   output lcdw_res_type               res
);

   logic [BYTE_W-1:0] wr_ticks_ff, rd_ticks_ff;
   logic              reverse_ff;
   lcdw_phase_type    phase_ff, phase_in;
   logic [BYTE_W-1:0] tick_ff, tick_in, tick_inc;
   logic              rs_ff, rs_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ticks_ff <= WRITE_TICKS_RST;
         rd_ticks_ff <= READ_TICKS_RST;
         reverse_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WRITE_TICKS: wr_ticks_ff <= csr_wdata;
            CSR_READ_TICKS:  rd_ticks_ff <= csr_wdata;
            CSR_REVERSE:     reverse_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign tick_inc = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      rs_in         = rs_ff;
      byte_in       = byte_ff;
      res.pin_rs    = 1'b0;
      res.pin_rw    = 1'b1;
      res.pin_en    = 1'b0;
      res.pin_data  = '0;
      res.drive_bus = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (opcode) begin
               rs_in         = is_data;
               byte_in       = reverse_ff ? flip8(write_byte) : write_byte;
               phase_in      = PH_WRITE;
               tick_in       = '0;
               res.pin_rs    = is_data;
               res.pin_rw    = 1'b0;
               res.pin_en    = 1'b1;
               res.drive_bus = 1'b1;
               res.pin_data  = byte_in;
            end
         end
         PH_WRITE: begin
            tick_in       = tick_inc;
            res.pin_rs    = rs_ff;
            res.pin_rw    = 1'b0;
            res.drive_bus = 1'b1;
            res.pin_data  = byte_ff;
            if (tick_inc >= wr_ticks_ff) begin
               phase_in = PH_GAP;
            end else begin
               res.pin_en = 1'b1;
            end
         end
         PH_GAP: begin
            phase_in   = PH_READ;
            tick_in    = '0;
            res.pin_en = 1'b1;
         end
         PH_READ: begin
            tick_in = tick_inc;
            if (tick_inc >= rd_ticks_ff) begin
               phase_in = busy_pin ? PH_GAP : PH_IDLE;
            end else begin
               res.pin_en = 1'b1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      res.ready_res = (phase_in == PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         rs_ff    <= 1'b0;
         byte_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         rs_ff    <= rs_in;
         byte_ff  <= byte_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/lcdw_obuf.sv
// Two-entry result buffer (output register plus skid stage).
// Depends on lcdw_pkg.
`default_nettype none
module lcdw_obuf
   import lcdw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire lcdw_res_type push_res,
   output logic              space,
   output logic              out_valid,
   input  wire logic         out_ready,
   output lcdw_res_type      out_res
);

   logic         main_vld_ff, skid_vld_ff;
   lcdw_res_type main_ff, skid_ff;
   logic         pop;

   assign pop       = main_vld_ff & out_ready;
   assign space     = ~skid_vld_ff;
   assign out_valid = main_vld_ff;
   assign out_res   = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (push) begin
         main_vld_ff <= 1'b1;
         if (main_vld_ff && !pop) begin
            skid_vld_ff <= 1'b1;
         end
      end else if (pop) begin
         main_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (!main_vld_ff || pop) begin
            main_ff <= push_res;
         end else begin
            skid_ff <= push_res;
         end
      end
   end

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the character LCD write sequencer with busy-flag polling.
// Needs lcdw_pkg and char_lcd_write_busy_poll; predicts every pin state and checks
// each result item in order, under several register settings and idling patterns.
`timescale 1ns / 100ps

module tb_top;
   import lcdw_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [CSR_IW-1:0] csr_addr = '0;
   logic [BYTE_W-1:0] csr_wdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;
   logic [REQ_UW-1:0] req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;

   char_lcd_write_busy_poll dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predicted sequencer state and register copies
   lcdw_phase_type    lcd_phase = PH_IDLE;
   logic [BYTE_W-1:0] tick_cnt = '0;
   logic              latched_rs = 1'b0;
   logic [BYTE_W-1:0] latched_byte = '0;
   logic [BYTE_W-1:0] wr_ticks = WRITE_TICKS_RST;
   logic [BYTE_W-1:0] rd_ticks = READ_TICKS_RST;
   logic              rev_en = 1'b1;

   lcdw_res_type pin_q[$];

   int src_idle_pct = 0;
   int rx_stall_pct = 0;
   int rx_hold = 0;
   int n_items = 0;
   int n_writes = 0;
   int n_repolls = 0;
   int n_settings = 0;
   int n_checked = 0;
   int n_bad = 0;

   function automatic lcdw_res_type lcd_tick_predict(input logic op, input logic dat,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic bsy);
      lcdw_res_type      r;
      logic [BYTE_W-1:0] flipped;
      flipped = {<<{b}};
      r = '0;
      r.pin_rw = 1'b1;
      case (lcd_phase)
         PH_IDLE: begin
            if (op) begin
               latched_rs = dat;
               latched_byte = rev_en ? flipped : b;
               lcd_phase = PH_WRITE;
               tick_cnt = '0;
               r.pin_rs = latched_rs;
               r.pin_rw = 1'b0;
               r.pin_en = 1'b1;
               r.drive_bus = 1'b1;
               r.pin_data = latched_byte;
               n_writes++;
            end
         end
         PH_WRITE: begin
            if (tick_cnt != TICK_MAX) tick_cnt++;
            r.pin_rs = latched_rs;
            r.pin_rw = 1'b0;
            r.drive_bus = 1'b1;
            r.pin_data = latched_byte;
            if (tick_cnt >= wr_ticks) begin
               lcd_phase = PH_GAP;
            end else begin
               r.pin_en = 1'b1;
            end
         end
         PH_GAP: begin
            lcd_phase = PH_READ;
            tick_cnt = '0;
            r.pin_en = 1'b1;
         end
         default: begin
            if (tick_cnt != TICK_MAX) tick_cnt++;
            if (tick_cnt >= rd_ticks) begin
               lcd_phase = bsy ? PH_GAP : PH_IDLE;
               if (bsy) n_repolls++;
            end else begin
               r.pin_en = 1'b1;
            end
         end
      endcase
      r.ready_res = (lcd_phase == PH_IDLE);
      return r;
   endfunction

   // true when the next tick ends a read pulse, i.e. busy is sampled
   function automatic logic busy_sampled_next();
      return lcd_phase == PH_READ && (int'(tick_cnt) + 1 >= int'(rd_ticks));
   endfunction

   // called at a falling edge; returns at a falling edge with tvalid left high
   task automatic drive_tick(input logic op, input logic dat, input logic [BYTE_W-1:0] b,
                             input logic bsy);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DW-BYTE_W-1){1'b0}}, bsy, b};
      req_tuser <= {dat, op};
      do @(posedge clock); while (!req_tready);
      pin_q.push_back(lcd_tick_predict(op, dat, b, bsy));
      n_items++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pin_q.size() != 0) @(negedge clock);
   endtask

   task automatic set_config(input logic [BYTE_W-1:0] w, input logic [BYTE_W-1:0] r,
                             input logic [BYTE_W-1:0] rv);
      drain_results();
      csr_we <= 1'b1;
      csr_addr <= CSR_WRITE_TICKS;
      csr_wdata <= w;
      @(negedge clock);
      csr_addr <= CSR_READ_TICKS;
      csr_wdata <= r;
      @(negedge clock);
      csr_addr <= CSR_REVERSE;
      csr_wdata <= rv;
      @(negedge clock);
      csr_we <= 1'b0;
      wr_ticks = w;
      rd_ticks = r;
      rev_en = rv[0];
      n_settings++;
   endtask

   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold <= rx_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      lcdw_res_type want;
      lcdw_res_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = lcdw_res_type'(rsp_tdata[$bits(lcdw_res_type)-1:0]);
         if (pin_q.size() == 0) begin
            if (n_bad < 10) $display("unexpected result item %h", rsp_tdata);
            n_bad++;
         end else begin
            want = pin_q.pop_front();
            n_checked++;
            if (got !== want || rsp_tdata[RSP_DW-1:$bits(lcdw_res_type)] !== '0) begin
               if (n_bad < 10)
                  $display({"mismatch at item %0d: expected rs=%b rw=%b en=%b data=%h ",
                            "drive=%b ready=%b, got rs=%b rw=%b en=%b data=%h drive=%b ",
                            "ready=%b pad=%h"},
                           n_checked, want.pin_rs, want.pin_rw, want.pin_en,
                           want.pin_data, want.drive_bus, want.ready_res, got.pin_rs,
                           got.pin_rw, got.pin_en, got.pin_data, got.drive_bus,
                           got.ready_res, rsp_tdata[RSP_DW-1:$bits(lcdw_res_type)]);
               n_bad++;
            end
         end
      end
   end

   // one write with the reset register values, run until idle again
   task automatic test_reset_defaults();
      drive_tick(1'b1, 1'b1, 8'h3C, 1'b0);
      while (lcd_phase != PH_IDLE) drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
      drain_results();
   endtask

   task automatic test_directed();
      set_config(8'd0, 8'd2, 8'h01);
      drive_tick(1'b0, 1'b1, 8'hFF, 1'b1);   // idle tick, busy ignored
      drive_tick(1'b1, 1'b0, 8'h01, 1'b0);   // command, reversed
      drive_tick(1'b1, 1'b1, 8'hFF, 1'b1);   // write while busy, data hold
      drive_tick(1'b0, 1'b0, 8'h00, 1'b0);   // gap
      drive_tick(1'b0, 1'b0, 8'h00, 1'b1);   // read, busy not sampled
      drive_tick(1'b0, 1'b0, 8'h00, 1'b1);   // read ends busy
      drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
      drive_tick(1'b1, 1'b0, 8'hAA, 1'b0);
      drive_tick(1'b0, 1'b0, 8'h00, 1'b0);   // read ends not busy
      set_config(8'd1, 8'd0, 8'h00);
      drive_tick(1'b1, 1'b1, 8'hFF, 1'b0);
      drive_tick(1'b0, 1'b1, 8'h00, 1'b1);
      drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
      drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
      drive_tick(1'b1, 1'b0, 8'h00, 1'b0);
      drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
      drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
      drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
      drive_tick(1'b1, 1'b1, 8'h81, 1'b0);
      drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
      drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
      drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
      drain_results();
   endtask

   // longest write pulse: tick counter runs up to its top value
   task automatic test_longest_pulses();
      set_config(8'd255, 8'd1, 8'hFE);
      drive_tick(1'b1, 1'b0, 8'h5A, 1'b0);
      while (lcd_phase != PH_IDLE)
         drive_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                    busy_sampled_next() ? 1'b0 : 1'($urandom_range(1)));
      drain_results();
   endtask

   // receiver holds off while the sender keeps going, so the input stalls
   task automatic test_backpressure();
      set_config(8'd3, 8'd2, 8'h01);
      src_idle_pct = 0;
      rx_hold = 60;
      repeat (30)
         drive_tick(lcd_phase == PH_IDLE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    1'($urandom_range(1)));
      drain_results();
   endtask

   task automatic test_random(input int n, input int src_pct, input int rx_pct);
      logic              op;
      logic              bsy;
      logic [BYTE_W-1:0] w;
      logic [BYTE_W-1:0] r;
      w = ($urandom_range(9) == 0) ? 8'd1 : 8'($urandom_range(0, 4));
      r = ($urandom_range(9) == 0) ? 8'd1 : 8'($urandom_range(0, 4));
      set_config(w, r, 8'($urandom_range(255)));
      src_idle_pct = src_pct;
      rx_stall_pct = rx_pct;
      repeat (n) begin
         if (lcd_phase == PH_IDLE) op = ($urandom_range(99) < 70);
         else op = ($urandom_range(99) < 15);
         if (busy_sampled_next()) bsy = ($urandom_range(99) < 40);
         else bsy = 1'($urandom_range(1));
         drive_tick(op, 1'($urandom_range(1)), 8'($urandom_range(255)), bsy);
      end
      drain_results();
      src_idle_pct = 0;
      rx_stall_pct = 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_directed();
      test_longest_pulses();
      test_backpressure();
      test_random(50, 0, 0);
      test_random(50, 65, 0);
      test_random(50, 0, 65);
      test_random(50, 29, 29);
      repeat (10) @(posedge clock);
      $display("Ran %0d items over %0d register settings: %0d LCD writes, %0d busy re-polls.",
               n_items, n_settings, n_writes, n_repolls);
      $display("%0d result items checked, %0d failures.", n_checked, n_bad);
      if (n_bad == 0 && pin_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d result items outstanding", pin_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
